FILE: design/abp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package abp_pkg;

  // Default depth of the block store.
  localparam int BLOCK_MAX_DEF = 64;

  // Width of the configuration data bus and of the signed address terms.
  localparam int CFG_W = 32;
  // Width of the block length register.
  localparam int LEN_REG_W = 7;
  // Width of the register index.
  localparam int IDX_W = 2;

  // Input command codes.
  localparam logic CMD_DATA  = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_BLOCK_LEN = 2'd0;
  localparam logic [IDX_W-1:0] REG_MULT      = 2'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET    = 2'd2;

  // First bit handled by the Horner loop; bit 31 seeds the remainder.
  localparam logic [4:0] TOP_BIT = 5'd30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RED_MULT,
    ST_RED_OFFSET,
    ST_READ,
    ST_SHOW
  } state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic rd_clr;
  } store_ctrl_t;

endpackage

`default_nettype wire

FILE: design/abp_modunit.sv
`timescale 1ns / 1ps
`default_nettype none

// Shared modular adder: (a + b + cin) mod n for a, b < n.
module abp_modunit #(
  parameter int BLOCK_MAX = abp_pkg::BLOCK_MAX_DEF
) (
  input  wire logic [$clog2(BLOCK_MAX+1)-1:0] n,
  input  wire logic [$clog2(BLOCK_MAX+1)-1:0] a,
  input  wire logic [$clog2(BLOCK_MAX+1)-1:0] b,
  input  wire logic                           cin,
  output      logic [$clog2(BLOCK_MAX+1)-1:0] res
);

  localparam int LW = $clog2(BLOCK_MAX + 1);

  logic [LW:0] sum;
  logic [LW:0] diff;

  always_comb begin
    sum  = {1'b0, a} + {1'b0, b} + {{LW{1'b0}}, cin};
    diff = sum - {1'b0, n};
    res  = (sum >= {1'b0, n}) ? diff[LW-1:0] : sum[LW-1:0];
  end

endmodule

`default_nettype wire

FILE: design/abp_store.sv
`timescale 1ns / 1ps
`default_nettype none

// Block store: one write port, one registered read port, per-entry valid
// bits so that reset and clear-on-read act at once.
module abp_store #(
  parameter int BLOCK_MAX = abp_pkg::BLOCK_MAX_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire abp_pkg::store_ctrl_t    ctrl,
  input  wire logic [((BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1)-1:0] wr_addr,
  input  wire logic [7:0]              wr_data,
  input  wire logic [((BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1)-1:0] rd_addr,
  output      logic [7:0]              rd_byte
);

  logic [7:0]           mem [BLOCK_MAX];
  logic [BLOCK_MAX-1:0] vld;
  logic [7:0]           rd_data;
  logic                 rd_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctrl.wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      if (ctrl.rd_en && ctrl.rd_clr) begin
        vld[rd_addr] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_data <= mem[rd_addr];
      rd_vld  <= vld[rd_addr];
    end
  end

  assign rd_byte = rd_vld ? rd_data : 8'd0;

endmodule

`default_nettype wire

FILE: design/abp_seq.sv
`timescale 1ns / 1ps
`default_nettype none

// Sequencer: fill, reduce mult and offset mod n, then walk the read addresses.
module abp_seq #(
  parameter int BLOCK_MAX = abp_pkg::BLOCK_MAX_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output      logic                              in_ready,
  input  wire logic                              cmd,
  output      logic                              out_valid,
  input  wire logic                              out_ready,
  output      logic                              last,
  input  wire logic [$clog2(BLOCK_MAX+1)-1:0]    n,
  input  wire logic [abp_pkg::CFG_W-1:0]         mult,
  input  wire logic [abp_pkg::CFG_W-1:0]         offset,
  output      logic [$clog2(BLOCK_MAX+1)-1:0]    op_a,
  output      logic [$clog2(BLOCK_MAX+1)-1:0]    op_b,
  output      logic                              op_cin,
  input  wire logic [$clog2(BLOCK_MAX+1)-1:0]    op_res,
  output      abp_pkg::store_ctrl_t              sctrl,
  output      logic [((BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1)-1:0] wr_addr,
  output      logic [((BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1)-1:0] rd_addr
);

  localparam int LW = $clog2(BLOCK_MAX + 1);
  localparam int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;

  abp_pkg::state_t state, state_next;

  logic [LW-1:0] fill;
  logic [LW-1:0] fill_inc;
  logic          clr_mode;
  logic [4:0]    bitcnt;
  logic [LW-1:0] red;
  logic [LW-1:0] step;
  logic [LW-1:0] addr;
  logic [AW-1:0] idx;
  logic [LW-1:0] n_m1;
  logic [LW-1:0] mult_seed;
  logic [LW-1:0] offset_seed;
  logic          data_txn;
  logic          flush_txn;

  always_comb begin
    fill_inc    = fill + 1'b1;
    n_m1        = n - 1'b1;
    // Sign bit carries weight -2^31, so it seeds the remainder with -1 mod n.
    mult_seed   = mult[abp_pkg::CFG_W-1] ? n_m1 : '0;
    offset_seed = offset[abp_pkg::CFG_W-1] ? n_m1 : '0;
    data_txn    = (state == abp_pkg::ST_IDLE) && in_valid && (cmd == abp_pkg::CMD_DATA);
    flush_txn   = (state == abp_pkg::ST_IDLE) && in_valid && (cmd == abp_pkg::CMD_FLUSH);
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      abp_pkg::ST_IDLE: begin
        if (data_txn && (fill_inc >= n)) begin
          state_next = abp_pkg::ST_RED_MULT;
        end else if (flush_txn && (fill != '0)) begin
          state_next = abp_pkg::ST_RED_MULT;
        end
      end
      abp_pkg::ST_RED_MULT: begin
        if (bitcnt == '0) begin
          state_next = abp_pkg::ST_RED_OFFSET;
        end
      end
      abp_pkg::ST_RED_OFFSET: begin
        if (bitcnt == '0) begin
          state_next = abp_pkg::ST_READ;
        end
      end
      abp_pkg::ST_READ: begin
        state_next = abp_pkg::ST_SHOW;
      end
      abp_pkg::ST_SHOW: begin
        if (out_ready) begin
          state_next = last ? abp_pkg::ST_IDLE : abp_pkg::ST_READ;
        end
      end
      default: begin
        state_next = abp_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready     = (state == abp_pkg::ST_IDLE);
    out_valid    = (state == abp_pkg::ST_SHOW);
    sctrl.wr_en  = data_txn;
    sctrl.rd_en  = (state == abp_pkg::ST_READ);
    sctrl.rd_clr = clr_mode;
    wr_addr      = fill[AW-1:0];
    rd_addr      = addr[AW-1:0];
    if (state == abp_pkg::ST_SHOW) begin
      op_a   = addr;
      op_b   = step;
      op_cin = 1'b0;
    end else begin
      op_a   = red;
      op_b   = red;
      op_cin = (state == abp_pkg::ST_RED_OFFSET) ? offset[bitcnt] : mult[bitcnt];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= abp_pkg::ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      if (data_txn) begin
        fill <= (fill_inc >= n) ? '0 : fill_inc;
      end else if (flush_txn) begin
        fill <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      abp_pkg::ST_IDLE: begin
        clr_mode <= data_txn;
        red      <= mult_seed;
        bitcnt   <= abp_pkg::TOP_BIT;
      end
      abp_pkg::ST_RED_MULT: begin
        if (bitcnt == '0) begin
          step   <= op_res;
          red    <= offset_seed;
          bitcnt <= abp_pkg::TOP_BIT;
        end else begin
          red    <= op_res;
          bitcnt <= bitcnt - 1'b1;
        end
      end
      abp_pkg::ST_RED_OFFSET: begin
        red    <= op_res;
        bitcnt <= bitcnt - 1'b1;
        if (bitcnt == '0) begin
          addr <= op_res;
          idx  <= '0;
        end
      end
      abp_pkg::ST_READ: begin
        last <= ({{(LW-AW){1'b0}}, idx} == n_m1);
      end
      abp_pkg::ST_SHOW: begin
        if (out_ready) begin
          addr <= op_res;
          idx  <= idx + 1'b1;
        end
      end
      default: begin
        red <= red;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/affine_block_permuter.sv
`timescale 1ns / 1ps
`default_nettype none

// Affine block interleaver. Data bytes (cmd = data) are written in order into
// a store of up to BLOCK_MAX bytes; once block_len bytes are held, the block
// puts out block_len bytes, output i being store[(mult*i + offset) mod
// block_len] (non-negative residue), and each position read is cleared. A
// flush transaction (cmd = flush) on a partly filled block emits all
// block_len positions by the same rule without clearing; a flush on an empty
// block emits nothing. last marks the final byte of each emitted block.
// block_len of 0 acts as 1 and values above BLOCK_MAX act as BLOCK_MAX.
// Flow: a data byte that does not complete a block is only written. A
// completing byte or a non-empty flush starts an emit run: first the
// shared modular adder reduces mult and offset mod block_len one bit per
// cycle (Horner form), then each output byte is a store read, then the
// byte held on the output until out_ready. in_ready is low for the whole
// run.
// Configuration must only be written while the block is idle; the registers
// themselves take a write on any cycle.
module affine_block_permuter #(
  parameter int BLOCK_MAX = abp_pkg::BLOCK_MAX_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_wen,
  input  wire logic [abp_pkg::IDX_W-1:0]      cfg_idx,
  input  wire logic [abp_pkg::CFG_W-1:0]      cfg_data,
  // input channel
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic                           cmd,
  input  wire logic [7:0]                     data_byte,
  // output channel
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [7:0]                     out_byte,
  output      logic                           last
);

  localparam int LW = $clog2(BLOCK_MAX + 1);
  localparam int AW = (BLOCK_MAX > 1) ? $clog2(BLOCK_MAX) : 1;
  localparam logic [abp_pkg::LEN_REG_W-1:0] BlockMaxC = abp_pkg::LEN_REG_W'(BLOCK_MAX);

  // Configuration registers
  logic [abp_pkg::LEN_REG_W-1:0] block_len;
  logic [abp_pkg::CFG_W-1:0]     mult;
  logic [abp_pkg::CFG_W-1:0]     offset;

  // Effective block length, clamped to 1..BLOCK_MAX
  logic [LW-1:0] n;

  // Shared unit operands
  logic [LW-1:0] op_a;
  logic [LW-1:0] op_b;
  logic          op_cin;
  logic [LW-1:0] op_res;

  abp_pkg::store_ctrl_t sctrl;
  logic [AW-1:0]        wr_addr;
  logic [AW-1:0]        rd_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_len <= abp_pkg::LEN_REG_W'(1);
      mult      <= abp_pkg::CFG_W'(1);
      offset    <= '0;
    end else if (cfg_wen) begin
      unique case (cfg_idx)
        abp_pkg::REG_BLOCK_LEN: block_len <= cfg_data[abp_pkg::LEN_REG_W-1:0];
        abp_pkg::REG_MULT:      mult      <= cfg_data;
        abp_pkg::REG_OFFSET:    offset    <= cfg_data;
        default:                block_len <= block_len;  // no register here
      endcase
    end
  end

  always_comb begin
    if (block_len == '0) begin
      n = LW'(1);
    end else if (block_len > BlockMaxC) begin
      n = LW'(BLOCK_MAX);
    end else begin
      n = block_len[LW-1:0];
    end
  end

  abp_seq #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .last      (last),
    .n         (n),
    .mult      (mult),
    .offset    (offset),
    .op_a      (op_a),
    .op_b      (op_b),
    .op_cin    (op_cin),
    .op_res    (op_res),
    .sctrl     (sctrl),
    .wr_addr   (wr_addr),
    .rd_addr   (rd_addr)
  );

  // One adder with conditional subtract serves both the reductions and the
  // per-byte address step.
  abp_modunit #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_modunit (
    .n   (n),
    .a   (op_a),
    .b   (op_b),
    .cin (op_cin),
    .res (op_res)
  );

  abp_store #(
    .BLOCK_MAX (BLOCK_MAX)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sctrl),
    .wr_addr (wr_addr),
    .wr_data (data_byte),
    .rd_addr (rd_addr),
    .rd_byte (out_byte)
  );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

// Block interleaver bench: a queue-fed driver pushes byte/flush transactions,
// a clocked monitor checks every emitted byte against the local permutation
// model, and a watchdog catches hangs. Config is only touched between phases,
// once every pending output byte has drained.
module tb_top;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transaction at all
  localparam int END_WAIT       = 200;   // idle wait before the final report
  localparam int SETTLE         = 8;     // wait after a drain before config moves
  localparam int RANDOM_ITEMS   = 290;
  localparam int MAX_PRINTS     = 40;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data;
  } byte_txn_t;

  typedef struct packed {
    logic [7:0] val;
    logic       last;
  } perm_byte_t;

  // ---------------------------------------------------------------------------
  // DUT hookup; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        cfg_wen   = 1'b0;
  logic [abp_pkg::IDX_W-1:0]   cfg_idx   = abp_pkg::REG_BLOCK_LEN;
  logic [abp_pkg::CFG_W-1:0]   cfg_data  = '0;
  logic                        in_valid  = 1'b0;
  logic                        in_ready;
  logic                        cmd       = abp_pkg::CMD_DATA;
  logic [7:0]                  data_byte = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [7:0]                  out_byte;
  logic                        last;

  affine_block_permuter DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_wen   (cfg_wen),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .data_byte (data_byte),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Permutation model: its own copy of the store, fill count and registers
  // ---------------------------------------------------------------------------
  logic [7:0]        blk_mem [abp_pkg::BLOCK_MAX_DEF];
  logic [6:0]        fill_cnt;
  logic [6:0]        len_reg;
  logic signed [31:0] mult_reg;
  logic signed [31:0] offs_reg;
  perm_byte_t        perm_q [$];   // output bytes still owed by the DUT
  byte_txn_t         stim_q [$];   // transactions waiting for the driver

  int n_err;
  int n_in;
  int n_out;
  int full_blocks;
  int flush_blocks;
  int cfg_writes;
  bit calm;                        // phase with no idling on either side

  // Register value 0 behaves as 1, anything past the store depth as the depth.
  function automatic int unsigned eff_len();
    if (len_reg == 0) return 1;
    if (len_reg > abp_pkg::BLOCK_MAX_DEF) return abp_pkg::BLOCK_MAX_DEF;
    return 32'(len_reg);
  endfunction

  // Output i reads store[(mult*i + offset) mod n], non-negative residue,
  // formed in 64 bits so nothing wraps. A full block clears what it reads.
  function automatic void emit_permuted(bit clear_read);
    int unsigned n;
    int unsigned a;
    longint      x;
    longint      r;
    perm_byte_t  pb;
    n = eff_len();
    for (int unsigned i = 0; i < n; i++) begin
      x = longint'(mult_reg) * longint'(i) + longint'(offs_reg);
      r = x % longint'(n);
      if (r < 0) r = r + longint'(n);
      a = int'(r) & 63;
      pb.val  = blk_mem[a[5:0]];
      pb.last = (i + 1 == n);
      perm_q.push_back(pb);
      if (clear_read) blk_mem[a[5:0]] = '0;
    end
    fill_cnt = '0;
  endfunction

  function automatic void permute_step(logic c, logic [7:0] d);
    if (c == abp_pkg::CMD_FLUSH) begin
      // flush of an empty block emits nothing; the data field is don't-care
      if (fill_cnt != 0) begin
        emit_permuted(1'b0);
        flush_blocks++;
      end
    end else begin
      // byte lands at the fill position even when a lowered length is
      // already reached, then the block goes out at once
      blk_mem[fill_cnt[5:0]] = d;
      fill_cnt = fill_cnt + 7'd1;
      if (fill_cnt >= eff_len()) begin
        emit_permuted(1'b1);
        full_blocks++;
      end
    end
  endfunction

  // Mostly back-to-back, some short gaps, a few long ones.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Affine terms: extremes, small signed values, or anything.
  function automatic logic [abp_pkg::CFG_W-1:0] pick_term();
    case ($urandom_range(0, 5))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2, 3:    return $urandom_range(0, 16) - 8;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(string what);
    n_err++;
    if (n_err <= MAX_PRINTS) $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  task automatic send(logic c, logic [7:0] d);
    byte_txn_t t;
    t.cmd  = c;
    t.data = d;
    stim_q.push_back(t);
  endtask

  // Register write; the model follows on the edge that takes it.
  task automatic write_reg(logic [abp_pkg::IDX_W-1:0] idx,
                           logic [abp_pkg::CFG_W-1:0] val);
    @(posedge clk);
    cfg_wen  <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wen <= 1'b0;
    cfg_writes++;
    case (idx)
      abp_pkg::REG_BLOCK_LEN: len_reg  = val[abp_pkg::LEN_REG_W-1:0];
      abp_pkg::REG_MULT:      mult_reg = val;
      abp_pkg::REG_OFFSET:    offs_reg = val;
      default: ;
    endcase
  endtask

  // Sender holds off until everything queued is taken and every owed byte
  // is back, then lets a non-completing byte finish before config moves.
  task automatic drain(int unsigned settle);
    do @(negedge clk);
    while (stim_q.size() != 0 || in_valid || perm_q.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Input driver: one transaction from stim_q at a time, gap after each
  // ---------------------------------------------------------------------------
  int unsigned send_gap;

  always @(posedge clk) begin : drive_in
    byte_txn_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        permute_step(cmd, data_byte);
        n_in++;
      end
      // only touch the channel once the current transaction is gone
      if (!in_valid || in_ready) begin
        if (send_gap != 0) begin
          in_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (stim_q.size() != 0) begin
          nxt = stim_q.pop_front();
          in_valid  <= 1'b1;
          cmd       <= nxt.cmd;
          data_byte <= nxt.data;
          send_gap  <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output monitor: random back-pressure, field-by-field compare
  // ---------------------------------------------------------------------------
  int unsigned stall_cnt;

  always @(posedge clk) begin : watch_out
    perm_byte_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_cnt <= 0;
    end else begin
      if (out_valid && out_ready) begin
        n_out++;
        if (perm_q.size() == 0) begin
          report_mismatch($sformatf("byte %02h last=%0b with nothing owed", out_byte, last));
        end else begin
          want = perm_q.pop_front();
          if (out_byte !== want.val)
            report_mismatch($sformatf("out_byte %02h, model %02h", out_byte, want.val));
          if (last !== want.last)
            report_mismatch($sformatf("last %0b, model %0b (byte %02h)",
                                      last, want.last, want.val));
        end
      end
      if (stall_cnt != 0) begin
        out_ready <= 1'b0;
        stall_cnt <= stall_cnt - 1;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall_cnt <= pick_gap();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: counts cycles in which no transaction moves anywhere
  // ---------------------------------------------------------------------------
  int unsigned quiet;

  always @(posedge clk) begin : watchdog
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || cfg_wen) begin
      quiet <= 0;
    end else if (quiet == WATCHDOG_LIMIT) begin
      $display("watchdog: %0d cycles without a transaction, %0d bytes still owed",
               WATCHDOG_LIMIT, perm_q.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequencer
  // ---------------------------------------------------------------------------
  initial begin : run
    int unsigned n_sent;
    int unsigned n_items;
    int unsigned n;
    int unsigned phases;
    logic [abp_pkg::CFG_W-1:0] len_val;

    // model matches the DUT reset state
    foreach (blk_mem[k]) blk_mem[k] = '0;
    fill_cnt = '0;
    len_reg  = 7'd1;
    mult_reg = 32'sd1;
    offs_reg = 32'sd0;
    calm     = 1'b0;
    n_sent   = 0;
    phases   = 0;

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed part ---
    // reset config (length 1): extremes of the byte, flush on empty block
    // with a data field that must be ignored
    send(abp_pkg::CMD_DATA, 8'h00);
    send(abp_pkg::CMD_DATA, 8'hFF);
    send(abp_pkg::CMD_FLUSH, 8'hA5);
    drain(SETTLE);

    // length 4, mult -1, offset max positive; then a partial block flush that
    // reads back zeros left by the cleared block
    write_reg(abp_pkg::REG_BLOCK_LEN, 32'd4);
    write_reg(abp_pkg::REG_MULT, 32'hFFFF_FFFF);
    write_reg(abp_pkg::REG_OFFSET, 32'h7FFF_FFFF);
    send(abp_pkg::CMD_DATA, 8'h01);
    send(abp_pkg::CMD_DATA, 8'h80);
    send(abp_pkg::CMD_DATA, 8'h55);
    send(abp_pkg::CMD_DATA, 8'hAA);
    send(abp_pkg::CMD_DATA, 8'h33);
    send(abp_pkg::CMD_DATA, 8'h44);
    send(abp_pkg::CMD_FLUSH, 8'h5A);
    drain(SETTLE);

    // length 0 acts as 1; most negative affine terms
    write_reg(abp_pkg::REG_BLOCK_LEN, 32'd0);
    write_reg(abp_pkg::REG_MULT, 32'h8000_0000);
    write_reg(abp_pkg::REG_OFFSET, 32'h8000_0000);
    send(abp_pkg::CMD_DATA, 8'h12);
    drain(SETTLE);

    // length lowered mid-block: 5 bytes held at length 8, then length 3
    write_reg(abp_pkg::REG_BLOCK_LEN, 32'd8);
    write_reg(abp_pkg::REG_MULT, 32'd5);
    write_reg(abp_pkg::REG_OFFSET, 32'd1);
    for (int k = 0; k < 5; k++) send(abp_pkg::CMD_DATA, 8'hC0 + 8'(k));
    drain(SETTLE);
    write_reg(abp_pkg::REG_BLOCK_LEN, 32'd3);
    send(abp_pkg::CMD_DATA, 8'hC7);
    send(abp_pkg::CMD_DATA, 8'h3C);
    send(abp_pkg::CMD_DATA, 8'h96);
    send(abp_pkg::CMD_FLUSH, 8'h00);
    drain(SETTLE);

    // --- random part ---
    // each phase: maybe new registers (fill count carries over, so lengths
    // drop mid-block now and then), then mostly data with the odd flush
    while (n_sent < RANDOM_ITEMS) begin
      phases++;
      calm = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 4) != 0) begin
        case ($urandom_range(0, 15))
          0:       len_val = 64;
          1:       len_val = 0;
          2:       len_val = $urandom_range(65, 127);
          3, 4:    len_val = $urandom_range(13, 63);
          default: len_val = $urandom_range(1, 12);
        endcase
        write_reg(abp_pkg::REG_BLOCK_LEN, len_val);
        write_reg(abp_pkg::REG_MULT, pick_term());
        write_reg(abp_pkg::REG_OFFSET, pick_term());
      end
      n = eff_len();
      // large blocks get about one block; small ones a few
      n_items = (n > 16) ? n + $urandom_range(0, 4) : $urandom_range(1, 3 * n + 2);
      if (n_items > RANDOM_ITEMS - n_sent) n_items = RANDOM_ITEMS - n_sent;
      for (int unsigned k = 0; k < n_items; k++) begin
        if ($urandom_range(0, 11) == 0)
          send(abp_pkg::CMD_FLUSH, 8'($urandom_range(0, 255)));
        else
          send(abp_pkg::CMD_DATA, 8'($urandom_range(0, 255)));
      end
      n_sent += n_items;
      drain(SETTLE);
    end

    calm = 1'b0;
    repeat (END_WAIT) @(negedge clk);

    $display("Covered %0d input transactions over %0d random phases, %0d register writes.",
             n_in, phases, cfg_writes);
    $display("Checked %0d output bytes: %0d full blocks, %0d flushed partial blocks, %0d errors.",
             n_out, full_blocks, flush_blocks, n_err);
    if (n_err == 0 && perm_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      if (perm_q.size() != 0) $display("%0d output bytes never arrived", perm_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/abp_pkg.sv
design/abp_modunit.sv
design/abp_store.sv
design/abp_seq.sv
design/affine_block_permuter.sv
verif/tb_top.sv
